@@ rtl/bazot_pkg.sv @@
// ----------------------------------------------------------------------------
// bazot_pkg - shared types and constants
// Widths, reset values, register indexes and the controller/datapath
// command and status words of the altitude zero offset tracker.
// ----------------------------------------------------------------------------
package bazot_pkg;

	localparam int ELAPSED_W  = 8;
	localparam int ALT_W      = 31;
	localparam int CM_W       = 30;
	localparam int PERIOD_W   = 16;
	localparam int TICK_W     = 8;
	localparam int SKIP_W     = 3;
	localparam int CAL_W      = 16;
	localparam int PROD_W     = 16;
	localparam int CPROD_W    = 32;
	localparam int GUARD      = 8;
	localparam int ALT_EXT_W  = ALT_W + GUARD;
	localparam int OFF_W      = 40;
	localparam int SUM_W      = 45;
	localparam int DIFF_W     = 41;
	localparam int SCALE_W    = 48;
	localparam int DIV_W      = 48;
	localparam int DIV_DIGIT  = 8;
	localparam int DIV_STEPS  = DIV_W / DIV_DIGIT;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CM_LIMIT   = 512000000;
	localparam int DIV_ROUND  = 5;

	localparam logic [CFG_IDX_W-1:0] REG_READ_PERIOD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_TIME  = CFG_IDX_W'(1);

	localparam logic [PERIOD_W-1:0] READ_PERIOD_RST = 16'd20;
	localparam logic [PERIOD_W-1:0] CALIB_TIME_RST  = 16'd2000;

	typedef logic [ELAPSED_W-1:0]     elapsed_t;
	typedef logic signed [ALT_W-1:0]  alt_raw_t;
	typedef logic signed [CM_W-1:0]   alt_cm_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

	typedef struct packed {
		logic capture;
		logic prod;
		logic cmp;
		logic skip_inc;
		logic off_load;
		logic sum;
		logic mag;
		logic div_step;
		logic off_store;
		logic sub;
		logic mul;
		logic absval;
		logic sat;
		logic cal;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic taken;
		logic skip_full;
		logic calibrated;
		logic calib_zero;
		logic cal_done;
		logic flying;
	} dp_stat_t;

endpackage

@@ rtl/bazot_in_if.sv @@
// ----------------------------------------------------------------------------
// bazot_in_if - tick input channel
// Valid/ready channel carrying one task tick word.
// ----------------------------------------------------------------------------
interface bazot_in_if;
	import bazot_pkg::*;

	logic     valid;
	logic     ready;
	elapsed_t elapsed_ms;
	alt_raw_t altitude_raw;
	logic     flight_enabled;

	modport source(output valid, elapsed_ms, altitude_raw, flight_enabled, input ready);
	modport sink(input valid, elapsed_ms, altitude_raw, flight_enabled, output ready);
endinterface

@@ rtl/bazot_out_if.sv @@
// ----------------------------------------------------------------------------
// bazot_out_if - result output channel
// Valid/ready channel carrying one result word per tick.
// ----------------------------------------------------------------------------
interface bazot_out_if;
	import bazot_pkg::*;

	logic    valid;
	logic    ready;
	logic    reading_taken;
	logic    offset_ready;
	alt_cm_t altitude_cm;

	modport source(output valid, reading_taken, offset_ready, altitude_cm, input ready);
	modport sink(input valid, reading_taken, offset_ready, altitude_cm, output ready);
endinterface

@@ rtl/bazot_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bazot_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bazot_cfg_if;
	import bazot_pkg::*;

	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/baro_altitude_zero_offset_tracker.sv @@
// ----------------------------------------------------------------------------
// baro_altitude_zero_offset_tracker - barometric altitude zero offset tracker
// A tick runs the tick product and period compare; a reading taken while
// calibrating also loads or averages the offset with the byte-serial divide
// by ten; once calibrated it is scaled to centimetres and, on the ground,
// averaged into the offset. One tick at a time, until its result word is loaded.
// Reset: counters, offset and held altitude clear; registers return to 20/2000.
// ----------------------------------------------------------------------------
module baro_altitude_zero_offset_tracker #(
	parameter int ALT_FRAC_BITS = 16,
	parameter int SKIP_READS    = 5
) (
	input logic         clk,
	input logic         arst_n,
	bazot_in_if.sink    tick_in,
	bazot_out_if.source res_out,
	bazot_cfg_if.sink   cfg
);
	import bazot_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg.ready = 1'b1;

	bazot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick_in.valid),
		.in_ready  (tick_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bazot_dp #(
		.ALT_FRAC_BITS (ALT_FRAC_BITS),
		.SKIP_READS    (SKIP_READS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.elapsed_ms     (tick_in.elapsed_ms),
		.altitude_raw   (tick_in.altitude_raw),
		.flight_enabled (tick_in.flight_enabled),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.reading_taken  (res_out.reading_taken),
		.offset_ready   (res_out.offset_ready),
		.altitude_cm    (res_out.altitude_cm)
	);

endmodule

@@ rtl/bazot_ctrl.sv @@
// ----------------------------------------------------------------------------
// bazot_ctrl - tracker sequencer
// State machine that steps the datapath through one tick: tick product,
// period compare, offset averaging with the serial divide-by-ten, and the
// centimetre scaling, then hands the result to the output register.
// ----------------------------------------------------------------------------
module bazot_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  bazot_pkg::dp_stat_t stat,
	output bazot_pkg::dp_cmd_t  cmd
);
	import bazot_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] ST_PROD  = 4'd1;
	localparam logic [ST_W-1:0] ST_CMP   = 4'd2;
	localparam logic [ST_W-1:0] ST_SUM   = 4'd3;
	localparam logic [ST_W-1:0] ST_MAG   = 4'd4;
	localparam logic [ST_W-1:0] ST_DIV   = 4'd5;
	localparam logic [ST_W-1:0] ST_STORE = 4'd6;
	localparam logic [ST_W-1:0] ST_SUB   = 4'd7;
	localparam logic [ST_W-1:0] ST_MUL   = 4'd8;
	localparam logic [ST_W-1:0] ST_ABS   = 4'd9;
	localparam logic [ST_W-1:0] ST_SAT   = 4'd10;
	localparam logic [ST_W-1:0] ST_CAL   = 4'd11;
	localparam logic [ST_W-1:0] ST_OUT   = 4'd12;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	logic [ST_W-1:0]      state_q;
	logic [ST_W-1:0]      state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 ret_cal_q;
	logic                 ret_cal_d;
	logic                 out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		ret_cal_d = ret_cal_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				if (!stat.taken) begin
					state_d = ST_OUT;
				end else if (!stat.skip_full) begin
					cmd.skip_inc = 1'b1;
					state_d      = ST_OUT;
				end else if (!stat.calibrated) begin
					if (stat.calib_zero) begin
						cmd.off_load = 1'b1;
						state_d      = ST_CAL;
					end else begin
						ret_cal_d = 1'b1;
						state_d   = ST_SUM;
					end
				end else begin
					state_d = ST_SUB;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_MAG;
			end
			ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.off_store = 1'b1;
				state_d       = ret_cal_q ? ST_CAL : ST_OUT;
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ABS;
			end
			ST_ABS: begin
				cmd.absval = 1'b1;
				state_d    = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat = 1'b1;
				if (!stat.flying) begin
					ret_cal_d = 1'b0;
					state_d   = ST_SUM;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_CAL: begin
				cmd.cal = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			ret_cal_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_cal_q <= ret_cal_d;
			if (cmd.mag) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/bazot_dp.sv @@
// ----------------------------------------------------------------------------
// bazot_dp - tracker datapath
// Tick and calibration counters, the zero offset with its exponential
// average (divide by ten one byte per cycle), the centimetre scaling with
// rounding and saturation, configuration registers and the result register.
// ----------------------------------------------------------------------------
module bazot_dp #(
	parameter int ALT_FRAC_BITS = 16,
	parameter int SKIP_READS    = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bazot_pkg::dp_cmd_t   cmd,
	output bazot_pkg::dp_stat_t  stat,
	input  bazot_pkg::elapsed_t  elapsed_ms,
	input  bazot_pkg::alt_raw_t  altitude_raw,
	input  logic                 flight_enabled,
	input  logic                 cfg_we,
	input  bazot_pkg::cfg_idx_t  cfg_index,
	input  bazot_pkg::cfg_data_t cfg_data,
	output logic                 reading_taken,
	output logic                 offset_ready,
	output bazot_pkg::alt_cm_t   altitude_cm
);
	import bazot_pkg::*;

	localparam logic signed [SCALE_W:0] ROUND_HALF =
		(SCALE_W + 1)'(64'd1 << (ALT_FRAC_BITS - 1));
	localparam logic [SKIP_W-1:0]  SKIP_MAX = SKIP_W'(SKIP_READS);
	localparam logic [SCALE_W:0]   CM_MAX   = (SCALE_W + 1)'(CM_LIMIT);

	// configuration and tracker state
	logic [PERIOD_W-1:0]      period_q;
	logic [PERIOD_W-1:0]      calib_time_q;
	logic [TICK_W-1:0]        tick_q;
	logic [SKIP_W-1:0]        skip_q;
	logic [CAL_W-1:0]         calib_q;
	logic                     calibrated_q;
	logic signed [OFF_W-1:0]  off_q;
	logic signed [CM_W-1:0]   hold_q;

	// working registers
	elapsed_t                 elapsed_q;
	alt_raw_t                 alt_q;
	logic                     flight_q;
	logic                     taken_q;
	logic [PROD_W-1:0]        prod_q;
	logic [CPROD_W-1:0]       cprod_q;
	logic signed [SUM_W-1:0]  s_q;
	logic                     neg_q;
	logic [DIV_W-1:0]         div_n_q;
	logic [3:0]               rem_q;
	logic signed [DIFF_W-1:0] d_q;
	logic signed [SCALE_W-1:0] p_q;
	logic                     dneg_q;
	logic [SCALE_W:0]         m_q;
	logic                     out_taken_q;
	logic                     out_ready_q;
	alt_cm_t                  out_cm_q;

	logic signed [ALT_EXT_W-1:0] alt_ext;
	logic signed [SUM_W-1:0]     off_x;
	logic signed [SUM_W-1:0]     alt_x;
	logic signed [SUM_W:0]       s_x;
	logic signed [SUM_W:0]       mag_w;
	logic [3:0]                  div_r;
	logic [4:0]                  div_t;
	logic [DIV_W-1:0]            div_n;
	logic signed [OFF_W-1:0]     quo;
	logic signed [SCALE_W-1:0]   d_x;
	logic signed [SCALE_W:0]     p_x;
	logic [SCALE_W:0]            sh;
	logic signed [CM_W-1:0]      mag_cm;

	assign alt_ext = {alt_q, {GUARD{1'b0}}};
	assign off_x   = {{(SUM_W - OFF_W){off_q[OFF_W-1]}}, off_q};
	assign alt_x   = {{(SUM_W - ALT_EXT_W){alt_ext[ALT_EXT_W-1]}}, alt_ext};
	assign s_x     = {s_q[SUM_W-1], s_q};
	assign mag_w   = s_q[SUM_W-1] ? ((SUM_W + 1)'(DIV_ROUND) - s_x)
	                              : (s_x + (SUM_W + 1)'(DIV_ROUND));
	assign quo     = div_n_q[OFF_W-1:0];
	assign d_x     = {{(SCALE_W - DIFF_W){d_q[DIFF_W-1]}}, d_q};
	assign p_x     = {p_q[SCALE_W-1], p_q};
	assign sh      = m_q >> ALT_FRAC_BITS;
	assign mag_cm  = (sh > CM_MAX) ? CM_W'(CM_LIMIT) : sh[CM_W-1:0];

	// one quotient byte of the divide by ten
	always_comb begin
		div_r = rem_q;
		div_n = div_n_q;
		div_t = '0;
		for (int i = 0; i < DIV_DIGIT; i++) begin
			div_t = {div_r, div_n[DIV_W-1]};
			div_n = {div_n[DIV_W-2:0], 1'b0};
			if (div_t >= 5'd10) begin
				div_t    = div_t - 5'd10;
				div_n[0] = 1'b1;
			end
			div_r = div_t[3:0];
		end
	end

	assign stat.taken      = (prod_q >= period_q);
	assign stat.skip_full  = (skip_q >= SKIP_MAX);
	assign stat.calibrated = calibrated_q;
	assign stat.calib_zero = (calib_q == '0);
	assign stat.cal_done   = (cprod_q >= CPROD_W'(calib_time_q));
	assign stat.flying     = flight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= READ_PERIOD_RST;
			calib_time_q <= CALIB_TIME_RST;
			tick_q       <= '0;
			skip_q       <= '0;
			calib_q      <= '0;
			calibrated_q <= 1'b0;
			off_q        <= '0;
			hold_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_READ_PERIOD: period_q     <= cfg_data;
					REG_CALIB_TIME:  calib_time_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.capture) begin
				tick_q <= tick_q + TICK_W'(1);
			end else if (cmd.cmp && stat.taken) begin
				tick_q <= '0;
			end
			if (cmd.skip_inc) begin
				skip_q <= skip_q + SKIP_W'(1);
			end
			if (cmd.off_load) begin
				off_q <= {{(OFF_W - ALT_EXT_W){alt_ext[ALT_EXT_W-1]}}, alt_ext};
			end else if (cmd.off_store) begin
				off_q <= neg_q ? -quo : quo;
			end
			if (cmd.cal) begin
				if (stat.cal_done) begin
					calibrated_q <= 1'b1;
				end else if (calib_q != '1) begin
					calib_q <= calib_q + CAL_W'(1);
				end
			end
			if (cmd.sat) begin
				hold_q <= dneg_q ? -mag_cm : mag_cm;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			elapsed_q <= elapsed_ms;
			alt_q     <= altitude_raw;
			flight_q  <= flight_enabled;
		end
		if (cmd.prod) begin
			prod_q <= PROD_W'(tick_q) * PROD_W'(elapsed_q);
		end
		if (cmd.cmp) begin
			taken_q <= stat.taken;
			cprod_q <= CPROD_W'(calib_q) * CPROD_W'(prod_q);
		end
		if (cmd.sum) begin
			s_q <= (off_x <<< 3) + off_x + alt_x;
		end
		if (cmd.mag) begin
			neg_q   <= s_q[SUM_W-1];
			rem_q   <= '0;
			div_n_q <= DIV_W'(mag_w[SUM_W-1:0]);
		end else if (cmd.div_step) begin
			div_n_q <= div_n;
			rem_q   <= div_r;
		end
		if (cmd.sub) begin
			d_q <= {{(DIFF_W - ALT_EXT_W){alt_ext[ALT_EXT_W-1]}}, alt_ext}
			     - {off_q[OFF_W-1], off_q};
		end
		if (cmd.mul) begin
			p_q <= (d_x <<< 6) + (d_x <<< 5) + (d_x <<< 2);
		end
		if (cmd.absval) begin
			dneg_q <= p_q[SCALE_W-1];
			m_q    <= p_q[SCALE_W-1] ? (ROUND_HALF - p_x) : (p_x + ROUND_HALF);
		end
		if (cmd.out_load) begin
			out_taken_q <= taken_q;
			out_ready_q <= calibrated_q;
			out_cm_q    <= hold_q;
		end
	end

	assign reading_taken = out_taken_q;
	assign offset_ready  = out_ready_q;
	assign altitude_cm   = out_cm_q;

endmodule

@@ rtl/bazot_chk.sv @@
// ----------------------------------------------------------------------------
// bazot_chk - port checker for the altitude zero offset tracker
// Watches the tick and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module bazot_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               reading_taken,
	input logic               offset_ready,
	input bazot_pkg::alt_cm_t altitude_cm
);
	import bazot_pkg::*;

	localparam logic signed [CM_W-1:0] CM_HI = CM_W'(CM_LIMIT);
	localparam logic signed [CM_W-1:0] CM_LO = -CM_HI;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(altitude_cm)
			&& $stable(reading_taken) && $stable(offset_ready))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("tick taken while previous tick in progress");

	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("no tick accepted after result issued");

	a_cm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> altitude_cm <= CM_HI && altitude_cm >= CM_LO)
		else $error("altitude out of saturation range");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && offset_ready |=> !out_valid || offset_ready)
		else $error("offset ready dropped after calibration");

endmodule

bind baro_altitude_zero_offset_tracker bazot_chk u_bazot_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (tick_in.valid),
	.in_ready      (tick_in.ready),
	.out_valid     (res_out.valid),
	.out_ready     (res_out.ready),
	.reading_taken (res_out.reading_taken),
	.offset_ready  (res_out.offset_ready),
	.altitude_cm   (res_out.altitude_cm)
);

@@ dv/baro_altitude_zero_offset_tracker_tb.sv @@
// ----------------------------------------------------------------------------
// baro_altitude_zero_offset_tracker_tb - altitude zero offset tracker testbench
// Drives task ticks through the tick channel and checks every result word
// against an in-bench tracker of the read schedule, skipped readings, offset
// averaging and centimetre output. Directed tests cover skipped readings,
// calibration, flight hold, saturation, zero and maximum read period and
// tick counter wrap. Random phases follow under several register settings,
// with random gaps on the tick channel and stalls on the result channel.
// ----------------------------------------------------------------------------
module baro_altitude_zero_offset_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bazot_pkg::*;

	localparam int FRAC_BITS     = 16;
	localparam int READS_SKIPPED = 5;
	localparam int QUIET_LIMIT   = 2000;
	localparam int ALT_SPAN      = 655360000;

	localparam alt_raw_t ALT_TOP    = 31'sh3FFF_FFFF;
	localparam alt_raw_t ALT_BOTTOM = 31'sh4000_0000;
	localparam alt_raw_t ALT_BASE   = 31'sd6553600;
	localparam alt_raw_t ALT_HIGH   = 31'sd13107200;

	typedef struct packed {
		logic    taken;
		logic    offset_ok;
		alt_cm_t cm;
	} alt_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bazot_in_if  tick_if();
	bazot_out_if res_if();
	bazot_cfg_if cfg_if();

	baro_altitude_zero_offset_tracker #(
		.ALT_FRAC_BITS(FRAC_BITS),
		.SKIP_READS(READS_SKIPPED)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_in(tick_if),
		.res_out(res_if),
		.cfg(cfg_if)
	);

	// tracker state as seen from outside
	logic [PERIOD_W-1:0] period_ms     = READ_PERIOD_RST;
	logic [PERIOD_W-1:0] calib_ms      = CALIB_TIME_RST;
	logic [TICK_W-1:0]   ticks         = '0;
	logic [SKIP_W-1:0]   skipped_reads = '0;
	logic [CAL_W-1:0]    cal_count     = '0;
	logic                cal_done      = 1'b0;
	longint              offset_acc    = 0;
	longint              hold_cm       = 0;

	alt_word_t words_due[$];
	int        mismatches = 0;
	int        quiet      = 0;
	int        stall_left = 0;
	bit        idle_on    = 1'b1;
	int        alt_walk   = ALT_BASE;
	logic      flying     = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint ema_tenth(longint old, longint sample);
		longint s;
		s = old * 9 + sample;
		return (s >= 0) ? (s + 5) / 10 : (s - 5) / 10;
	endfunction

	function automatic longint scale_cm(longint diff);
		longint mag;
		mag = (diff < 0) ? -diff * 100 : diff * 100;
		mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (mag > CM_LIMIT)
			mag = CM_LIMIT;
		return (diff < 0) ? -mag : mag;
	endfunction

	function automatic alt_word_t track_altitude(elapsed_t e, alt_raw_t a, logic fly);
		logic [PROD_W-1:0] prod;
		longint            alt_ext;
		alt_word_t         w;
		w.taken = 1'b0;
		ticks = ticks + 1'b1;
		prod = PROD_W'(ticks) * PROD_W'(e);
		if (prod >= period_ms) begin
			alt_ext = longint'(a) * 256;
			w.taken = 1'b1;
			ticks = '0;
			if (skipped_reads < READS_SKIPPED) begin
				skipped_reads = skipped_reads + 1'b1;
			end else if (!cal_done) begin
				offset_acc = (cal_count == 0) ? alt_ext : ema_tenth(offset_acc, alt_ext);
				if (longint'(cal_count) * longint'(prod) < longint'(calib_ms)) begin
					if (cal_count != '1)
						cal_count = cal_count + 1'b1;
				end else begin
					cal_done = 1'b1;
				end
			end else begin
				hold_cm = scale_cm(alt_ext - offset_acc);
				if (!fly)
					offset_acc = ema_tenth(offset_acc, alt_ext);
			end
		end
		w.offset_ok = cal_done;
		w.cm = alt_cm_t'(hold_cm);
		return w;
	endfunction

	function automatic alt_raw_t pick_altitude();
		int step;
		case ($urandom_range(0, 9))
			0: return alt_raw_t'($urandom);
			1: return alt_raw_t'(int'($urandom_range(0, 2 * ALT_SPAN)) - ALT_SPAN);
			default: begin
				step = int'($urandom_range(0, 262144)) - 131072;
				alt_walk = alt_walk + step;
				if (alt_walk > ALT_SPAN)
					alt_walk = ALT_SPAN;
				else if (alt_walk < -ALT_SPAN)
					alt_walk = -ALT_SPAN;
				return alt_raw_t'(alt_walk);
			end
		endcase
	endfunction

	task automatic send_tick(elapsed_t e, alt_raw_t a, logic fly);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			tick_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		tick_if.valid          <= 1'b1;
		tick_if.elapsed_ms     <= e;
		tick_if.altitude_raw   <= a;
		tick_if.flight_enabled <= fly;
		@(posedge clk);
		while (!tick_if.ready) @(posedge clk);
		words_due.push_back(track_altitude(e, a, fly));
		@(negedge clk);
	endtask

	task automatic send_noisy_tick(int max_elapsed);
		elapsed_t e;
		case ($urandom_range(0, 19))
			0: e = '0;
			1: e = '1;
			default: e = elapsed_t'($urandom_range(1, max_elapsed));
		endcase
		if ($urandom_range(0, 15) == 0)
			flying = ~flying;
		send_tick(e, pick_altitude(), flying);
	endtask

	task automatic wait_drained();
		tick_if.valid <= 1'b0;
		while (words_due.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		if (idx == REG_READ_PERIOD)
			period_ms = val;
		else if (idx == REG_CALIB_TIME)
			calib_ms = val;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_regs(cfg_data_t period, cfg_data_t calib);
		wait_drained();
		write_reg(REG_READ_PERIOD, period);
		write_reg(REG_CALIB_TIME, calib);
	endtask

	task automatic compare_field(string fld, logic signed [39:0] want,
			logic signed [39:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, fld, want, got);
			mismatches++;
		end
	endtask

	// reset values: 255 ms per tick reads every tick, first readings dropped
	task automatic test_skip_reads();
		send_tick('0, ALT_BASE, 1'b0);
		send_tick('1, ALT_TOP, 1'b1);
		send_tick('1, ALT_BOTTOM, 1'b0);
		send_tick('1, alt_raw_t'(ALT_SPAN), 1'b1);
		send_tick('1, alt_raw_t'(-ALT_SPAN), 1'b0);
		send_tick('1, '0, 1'b1);
		send_tick('1, ALT_BASE, 1'b0);
		send_tick('1, ALT_BASE + 31'sd65536, 1'b1);
		send_tick('1, ALT_BASE - 31'sd1, 1'b0);
	endtask

	// period above 255 so the product needs its full width
	task automatic test_calibration();
		int guard;
		guard = 0;
		set_regs(16'd300, 16'd3000);
		alt_walk = ALT_BASE;
		while (!cal_done && guard < 500) begin
			send_noisy_tick(255);
			guard++;
		end
		repeat (3) send_noisy_tick(255);
	endtask

	task automatic test_flight_hold();
		set_regs(16'd20, 16'd3000);
		repeat (3) send_tick(8'd20, ALT_BASE, 1'b0);
		repeat (4) send_tick(8'd20, ALT_HIGH, 1'b1);
		send_tick(8'd19, ALT_HIGH, 1'b0);
		send_tick(8'd19, ALT_HIGH, 1'b0);
		repeat (4) send_tick(8'd20, ALT_HIGH, 1'b0);
	endtask

	// zero period reads on every tick, even with a zero product
	task automatic test_output_saturation();
		set_regs(16'd0, 16'd3000);
		repeat (40) send_tick('0, ALT_BOTTOM, 1'b0);
		repeat (3) send_tick('0, ALT_TOP, 1'b1);
		repeat (40) send_tick('0, ALT_TOP, 1'b0);
		repeat (3) send_tick('0, ALT_BOTTOM, 1'b1);
	endtask

	task automatic test_tick_wrap();
		set_regs(16'd20, 16'd3000);
		repeat (256) send_tick('0, pick_altitude(), flying);
		send_tick(8'd10, pick_altitude(), flying);
		send_tick(8'd10, pick_altitude(), flying);
	endtask

	// largest product stays below the largest period
	task automatic test_max_period();
		set_regs(16'hFFFF, 16'd3000);
		repeat (20) send_tick('1, pick_altitude(), 1'b0);
	endtask

	task automatic test_random();
		set_regs(16'd20, 16'd0);
		repeat (300) send_noisy_tick(40);
		set_regs(16'd1, 16'hFFFF);
		repeat (250) send_noisy_tick(8);
		set_regs(16'd0, 16'd500);
		repeat (200) send_noisy_tick(30);
		set_regs(16'd300, 16'd1000);
		repeat (250) send_noisy_tick(255);
		set_regs(cfg_data_t'($urandom_range(1, 200)), cfg_data_t'($urandom));
		repeat (250) send_noisy_tick(60);
		set_regs(READ_PERIOD_RST, CALIB_TIME_RST);
		idle_on = 1'b0;
		repeat (200) send_noisy_tick(30);
	endtask

	always @(negedge clk) begin
		if (stall_left != 0) begin
			res_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			res_if.ready <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		alt_word_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (words_due.size() == 0) begin
				$display("%0t ns: result word with none expected, cm %0d", $time,
					res_if.altitude_cm);
				mismatches++;
			end else begin
				want = words_due.pop_front();
				compare_field("reading_taken", want.taken, res_if.reading_taken);
				compare_field("offset_ready", want.offset_ok, res_if.offset_ready);
				compare_field("altitude_cm", want.cm, res_if.altitude_cm);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		tick_if.valid          = 1'b0;
		tick_if.elapsed_ms     = '0;
		tick_if.altitude_raw   = '0;
		tick_if.flight_enabled = 1'b0;
		cfg_if.valid           = 1'b0;
		cfg_if.index           = REG_READ_PERIOD;
		cfg_if.data            = '0;
		res_if.ready           = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		test_skip_reads();
		test_calibration();
		test_flight_hold();
		test_output_saturation();
		test_tick_wrap();
		test_max_period();
		test_random();
		wait_drained();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && words_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
